// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker files of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is applied.
`define MM4_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Concurrent check that also holds while reset is applied.
`define MM4_ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== sv/mm4_pkg.sv =====
package mm4_pkg;

  // Default number of fraction bits of the fixed-point format.
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Matrix geometry.
  localparam int unsigned ELEMS  = 16;
  localparam int unsigned ADDR_W = 4;

  // Wide accumulator: four 64-bit terms need two guard bits.
  localparam int unsigned ACC_W = 66;

  // Queue between front and back.
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Command codes on the input beat.
  localparam logic [1:0] CMD_LOAD_LEFT  = 2'd0;
  localparam logic [1:0] CMD_LOAD_RIGHT = 2'd1;
  localparam logic [1:0] CMD_COMPUTE    = 2'd2;

  // Saturation limits.
  localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

  // Operation after classification.
  typedef enum logic [1:0] {
    OP_LOAD_LEFT  = 2'd0,
    OP_LOAD_RIGHT = 2'd1,
    OP_COMPUTE    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]         command;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         out_row;
    logic [1:0]         out_col;
    logic signed [31:0] product_value;
    logic               saturated;
    logic               last_of_run;
  } out_item_t;

  // Queue entry.
  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  addr;
    logic signed [31:0] value;
  } q_item_t;

endpackage

// ===== sv/matrix_multiply_4x4.sv =====
// 4x4 fixed-point matrix multiplier. Each input beat either writes one element of the stored
// left or right matrix, or asks for product[i][j] = sum over k of right[i][k] * left[k][j],
// which comes out as 16 beats in row-major order, the last one flagged. Elements are signed
// fixed point with FRAC_BITS fraction bits; each product is shifted right arithmetically, the
// four terms are summed exactly and the sum is saturated to 32 bits with a flag. Both
// matrices read as zero after reset. A write beat passes through the holding register and
// the queue to its store, and writes stream at one per cycle while the engine is not busy. A
// compute beat occupies the single shared multiplier for 64 multiply-adds, one per cycle
// while the output is not stalled, and its results pass through the operand, product,
// accumulate and output registers. A four-entry queue between the input classifier and the
// multiply engine keeps taking beats while a product is being computed.
module matrix_multiply_4x4 #(
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mm4_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mm4_pkg::out_item_t out_data_o
);
  import mm4_pkg::*;

  logic    push, full, q_valid, q_pop;
  q_item_t push_data, q_data;

  // Input classifier.
  mm4_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // Queue between classifier and engine.
  mm4_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .valid_o     (q_valid),
    .pop_i       (q_pop),
    .pop_data_o  (q_data)
  );

  // Stores and multiply-accumulate engine.
  mm4_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/mm4_front.sv =====
module mm4_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mm4_pkg::in_item_t in_data_i,
  output logic              push_o,
  output mm4_pkg::q_item_t  push_data_o,
  input  logic              full_i
);
  import mm4_pkg::*;

  logic     hold_q, hold_d;
  q_item_t  item_q, item_d;
  logic     accept;
  logic     legal;

  // The holding register stalls the input only while the queue is full.
  assign in_stall_o = hold_q & full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push_o     = hold_q & ~full_i;

  // Classify the beat; an unknown command is dropped here.
  always_comb begin
    legal        = 1'b1;
    item_d.addr  = {in_data_i.row, in_data_i.col};
    item_d.value = in_data_i.element_value;
    item_d.op    = OP_COMPUTE;
    case (in_data_i.command)
      CMD_LOAD_LEFT:  item_d.op = OP_LOAD_LEFT;
      CMD_LOAD_RIGHT: item_d.op = OP_LOAD_RIGHT;
      CMD_COMPUTE:    item_d.op = OP_COMPUTE;
      default:        legal     = 1'b0;
    endcase
  end

  // Keep the entry until the queue takes it.
  assign hold_d = (accept & legal) | (hold_q & full_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= 1'b0;
    end else begin
      hold_q <= hold_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && legal) begin
      item_q <= item_d;
    end
  end

  assign push_data_o = item_q;

endmodule

// ===== sv/mm4_fifo.sv =====
module mm4_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  mm4_pkg::q_item_t push_data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output mm4_pkg::q_item_t pop_data_o
);
  import mm4_pkg::*;

  q_item_t           mem_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;

  assign pop_data_o = mem_q[rd_q];

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// ===== sv/mm4_back.sv =====
module mm4_back #(
  parameter int unsigned FRAC_BITS = mm4_pkg::FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  mm4_pkg::q_item_t   q_data_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mm4_pkg::out_item_t out_data_o
);
  import mm4_pkg::*;

  // Stored matrices, row-major.
  logic signed [31:0] left_q  [ELEMS];
  logic signed [31:0] right_q [ELEMS];

  // Sequencer: the count holds {i, j, k}.
  logic       busy_q, busy_d;
  logic [5:0] cnt_q, cnt_d;
  logic       en;

  // Operand, product and accumulate stages.
  logic                    opv_q, pv_q, sv_q, out_valid_q;
  logic signed [31:0]      a_q, b_q;
  logic [5:0]              tag0_q, tag1_q;
  logic [3:0]              tag2_q;
  logic signed [63:0]      p_q, p_d, shifted;
  logic signed [ACC_W-1:0] acc_q, acc_d, term;
  out_item_t               out_q, out_d;
  logic [ACC_W-32:0]       high_bits;
  logic                    fits;

  // The whole pipeline advances unless a finished beat is held up.
  assign en      = ~out_valid_q | ~out_stall_i;
  assign q_pop_o = q_valid_i & ~busy_q;

  // Store writes; a compute item only starts the sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < ELEMS; n++) begin
        left_q[n]  <= '0;
        right_q[n] <= '0;
      end
    end else if (q_pop_o) begin
      case (q_data_i.op)
        OP_LOAD_LEFT:  left_q[q_data_i.addr]  <= q_data_i.value;
        OP_LOAD_RIGHT: right_q[q_data_i.addr] <= q_data_i.value;
        default: ;
      endcase
    end
  end

  // Sequencer walks 64 multiply-adds in i, j, k order.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (q_pop_o && q_data_i.op == OP_COMPUTE) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q && en) begin
      cnt_d = cnt_q + 6'd1;
      if (&cnt_q) begin
        busy_d = 1'b0;
      end
    end
  end

  // Multiply, align and accumulate.
  assign p_d       = 64'(a_q) * 64'(b_q);
  assign shifted   = p_q >>> FRAC_BITS;
  assign term      = ACC_W'(shifted);
  assign acc_d     = (tag1_q[1:0] == 2'd0) ? term : acc_q + term;

  // Saturate the wide sum to 32 bits.
  assign high_bits = acc_q[ACC_W-1:31];
  assign fits      = (&high_bits) | ~(|high_bits);

  always_comb begin
    out_d.out_row     = tag2_q[3:2];
    out_d.out_col     = tag2_q[1:0];
    out_d.last_of_run = &tag2_q;
    out_d.saturated   = ~fits;
    if (fits) begin
      out_d.product_value = acc_q[31:0];
    end else if (acc_q[ACC_W-1]) begin
      out_d.product_value = SAT_MIN;
    end else begin
      out_d.product_value = SAT_MAX;
    end
  end

  // Control state of the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      opv_q       <= 1'b0;
      pv_q        <= 1'b0;
      sv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      if (en) begin
        opv_q       <= busy_q;
        pv_q        <= opv_q;
        sv_q        <= pv_q & (tag1_q[1:0] == 2'd3);
        out_valid_q <= sv_q;
      end
    end
  end

  // Payload of the pipeline.
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (busy_q) begin
        a_q    <= right_q[{cnt_q[5:4], cnt_q[1:0]}];
        b_q    <= left_q[{cnt_q[1:0], cnt_q[3:2]}];
        tag0_q <= cnt_q;
      end
      if (opv_q) begin
        p_q    <= p_d;
        tag1_q <= tag0_q;
      end
      if (pv_q) begin
        acc_q  <= acc_d;
        tag2_q <= tag1_q[5:2];
      end
      if (sv_q) begin
        out_q <= out_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== sv/mm4_checker.sv =====
`include "assert_macros.svh"

module mm4_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input mm4_pkg::out_item_t out_data_o
);
  import mm4_pkg::*;

  // Once reset has been seen applied, no result beat is offered in the next cycle.
  `MM4_ASSERT_RST(a_no_out_in_reset, !rst_ni |=> !out_valid_o, "result beat during reset")

  // A stalled result beat stays offered and unchanged.
  `MM4_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "stalled result beat changed")

  // The run marker sits exactly on the bottom-right element.
  `MM4_ASSERT(a_last_pos, out_valid_o |-> (out_data_o.last_of_run == (out_data_o.out_row == 2'd3 && out_data_o.out_col == 2'd3)), "last_of_run on wrong element")

  // A clipped element carries one of the two limits.
  `MM4_ASSERT(a_sat_value, out_valid_o && out_data_o.saturated |-> out_data_o.product_value == SAT_MAX || out_data_o.product_value == SAT_MIN, "saturated beat without limit value")

endmodule

bind matrix_multiply_4x4 mm4_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
